@@ rtl/slrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sliding window rate limiter.
// No dependencies; compile first.
package slrl_pkg;

    localparam int unsigned SECOND_WINDOW_MS = 1000;
    localparam int unsigned MINUTE_WINDOW_MS = 60000;

    localparam int unsigned NOW_BITS      = 32;
    localparam int unsigned SEC_CNT_BITS  = 7;
    localparam int unsigned MIN_CNT_BITS  = 11;
    localparam int unsigned APB_ADDR_BITS = 5;
    localparam int unsigned APB_DATA_BITS = 32;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_RULE_PRESENT     = 3'd0;
    localparam reg_idx_t REG_LIMIT_ENABLED    = 3'd1;
    localparam reg_idx_t REG_PER_SECOND_LIMIT = 3'd2;
    localparam reg_idx_t REG_BURST_LIMIT      = 3'd3;
    localparam reg_idx_t REG_MINUTE_CAP       = 3'd4;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                    rule_present;
        logic                    limit_enabled;
        logic [SEC_CNT_BITS-1:0] per_second_limit;
        logic [SEC_CNT_BITS-1:0] burst_limit;
        logic [MIN_CNT_BITS-1:0] minute_cap;
    } cfg_t;

    // Control from the sequencer to one log.
    typedef struct packed {
        logic clear;
        logic run;
        logic push;
    } log_ctl_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WORK
    } state_t;

endpackage

@@ rtl/slrl_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready).
// Depends on slrl_pkg.
interface slrl_req_if
    import slrl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic                rule_hit;
    logic [NOW_BITS-1:0] now_ms;

    modport source (output valid, req_type, rule_hit, now_ms, input ready);
    modport sink   (input valid, req_type, rule_hit, now_ms, output ready);
endinterface

interface slrl_rsp_if
    import slrl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    allowed;
    logic [SEC_CNT_BITS-1:0] second_count;
    logic [MIN_CNT_BITS-1:0] minute_count;

    modport source (output valid, allowed, second_count, minute_count, input ready);
    modport sink   (input valid, allowed, second_count, minute_count, output ready);
endinterface

@@ rtl/slrl_cfg.sv @@
`timescale 1ns / 1ps
// APB configuration registers; pulses a log clear when rule_present is written 0.
// Depends on slrl_pkg.
module slrl_cfg
    import slrl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg,
    output logic                     log_clear
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    assign log_clear = wr_en && (idx == REG_RULE_PRESENT) && !pwdata[0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RULE_PRESENT:     cfg_next.rule_present     = pwdata[0];
                REG_LIMIT_ENABLED:    cfg_next.limit_enabled    = pwdata[0];
                REG_PER_SECOND_LIMIT: cfg_next.per_second_limit = pwdata[SEC_CNT_BITS-1:0];
                REG_BURST_LIMIT:      cfg_next.burst_limit      = pwdata[SEC_CNT_BITS-1:0];
                REG_MINUTE_CAP:       cfg_next.minute_cap       = pwdata[MIN_CNT_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RULE_PRESENT:     prdata = APB_DATA_BITS'(cfg_reg.rule_present);
            REG_LIMIT_ENABLED:    prdata = APB_DATA_BITS'(cfg_reg.limit_enabled);
            REG_PER_SECOND_LIMIT: prdata = APB_DATA_BITS'(cfg_reg.per_second_limit);
            REG_BURST_LIMIT:      prdata = APB_DATA_BITS'(cfg_reg.burst_limit);
            REG_MINUTE_CAP:       prdata = APB_DATA_BITS'(cfg_reg.minute_cap);
            default:              prdata = '0;
        endcase
    end

endmodule

@@ rtl/slrl_log.sv @@
`timescale 1ns / 1ps
// One circular timestamp log: RAM, head/fill pointers and the expiry engine.
// Depends on slrl_pkg.
module slrl_log
    import slrl_pkg::*;
#(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned TIME_BITS  = 32,
    parameter int unsigned WINDOW_MS  = 1000,
    parameter int unsigned COUNT_BITS = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  log_ctl_t              ctl,
    input  logic [TIME_BITS-1:0]  now,
    output logic                  done,
    output logic                  full,
    output logic [COUNT_BITS-1:0] count
);

    localparam int unsigned HW  = $clog2(DEPTH);
    localparam int unsigned FW  = $clog2(DEPTH + 1);
    localparam int unsigned SW  = FW + 1;
    localparam int unsigned CW  = (FW > COUNT_BITS) ? FW : COUNT_BITS;
    localparam int unsigned CMAX = (2 ** COUNT_BITS) - 1;

    logic [TIME_BITS-1:0] mem [DEPTH];

    logic [HW-1:0]        head_reg;
    logic [HW-1:0]        head_next;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;
    logic [TIME_BITS-1:0] rd_data_reg;  // always mem[head_reg]

    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic [HW-1:0]        head_inc;
    logic [SW-1:0]        tail_sum;
    logic [SW-1:0]        tail_wrap;
    logic [HW-1:0]        waddr;
    logic [CW-1:0]        fill_x;

    assign age      = now - rd_data_reg;
    assign expired  = (fill_reg != '0) && (age > TIME_BITS'(WINDOW_MS));
    assign done     = !expired;
    assign head_inc = (head_reg == HW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign full     = (fill_reg == FW'(DEPTH));

    assign tail_sum  = SW'(head_reg) + SW'(fill_reg);
    assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign waddr     = tail_wrap[HW-1:0];

    assign fill_x = CW'(fill_reg);
    assign count  = (fill_x > CW'(CMAX)) ? COUNT_BITS'(CMAX) : COUNT_BITS'(fill_x);

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        priority if (ctl.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (ctl.run && expired)
        begin
            head_next = head_inc;
            fill_next = fill_reg - 1'b1;
        end
        else if (ctl.push)
        begin
            if (full)
            begin
                head_next = head_inc;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Push writes the tail (the head slot when full); the read port tracks the next head.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[waddr] <= now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && (waddr == head_next))
        begin
            rd_data_reg <= now;
        end
        else
        begin
            rd_data_reg <= mem[head_next];
        end
    end

endmodule

@@ rtl/sliding_window_rate_limiter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the sliding window log rate limiter.
// Depends on slrl_pkg, slrl_if, slrl_cfg and slrl_log.
//
// Usage:
//  - req channel (valid/ready): req_type (check or query), rule_hit, now_ms.
//    One transfer in gives exactly one transfer out on the rsp channel:
//    allowed, second_count, minute_count.
//  - APB port programs rule_present, limit_enabled, per_second_limit,
//    burst_limit and the minute cap at byte addresses 0, 4, 8, 12, 16.
//    Writing rule_present to 0 empties both logs at once. Write only while
//    the block is idle. pready is tied high.
//  - Timing: after a request transfer the block pops expired entries, one per
//    cycle while any remain (both logs pop in parallel, so the larger pop
//    count counts), then decides and writes the result into the output
//    register. It takes no new request until it has decided on the current one.
//    The head-of-log RAM read paces the expiry loop.
//  - The output register holds the result while rsp.ready is low; the next
//    request may be taken meanwhile and then waits in its decision cycle
//    until the register frees.
//  - Reset clears the control registers, pointers and fill counts; the RAMs need no
//    clearing pass because entries beyond the fill are never read.
module sliding_window_rate_limiter_unit
    import slrl_pkg::*;
#(
    parameter int unsigned SECOND_DEPTH = 64,
    parameter int unsigned MINUTE_DEPTH = 1024,
    parameter int unsigned TIME_BITS    = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    slrl_req_if.sink                 req,
    slrl_rsp_if.source               rsp
);

    cfg_t     cfg;
    logic     log_clear;
    log_ctl_t sec_ctl;
    log_ctl_t min_ctl;
    logic     sec_done;
    logic     min_done;
    logic     sec_full;
    logic     min_full;
    logic [SEC_CNT_BITS-1:0] sec_count;
    logic [MIN_CNT_BITS-1:0] min_count;

    state_t state_reg;
    state_t state_next;

    // Captured request
    logic                 query_reg;
    logic                 pass_reg;     // unmatched or absent rule: no log activity
    logic [TIME_BITS-1:0] now_reg;

    // Output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_allowed_reg;
    logic [SEC_CNT_BITS-1:0] out_sec_reg;
    logic [MIN_CNT_BITS-1:0] out_min_reg;

    logic accept;
    logic out_free;
    logic finish;
    logic run;
    logic push;
    logic sec_block;
    logic min_block;
    logic check_ok;
    logic sec_grow;
    logic min_grow;
    logic [SEC_CNT_BITS-1:0] sec_cap;

    slrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .log_clear (log_clear)
    );

    slrl_log #(
        .DEPTH      (SECOND_DEPTH),
        .TIME_BITS  (TIME_BITS),
        .WINDOW_MS  (SECOND_WINDOW_MS),
        .COUNT_BITS (SEC_CNT_BITS)
    ) u_sec_log (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sec_ctl),
        .now   (now_reg),
        .done  (sec_done),
        .full  (sec_full),
        .count (sec_count)
    );

    slrl_log #(
        .DEPTH      (MINUTE_DEPTH),
        .TIME_BITS  (TIME_BITS),
        .WINDOW_MS  (MINUTE_WINDOW_MS),
        .COUNT_BITS (MIN_CNT_BITS)
    ) u_min_log (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (min_ctl),
        .now   (now_reg),
        .done  (min_done),
        .full  (min_full),
        .count (min_count)
    );

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Counts are saturated, so comparing against a 7/11-bit limit stays exact.
    assign sec_cap   = (cfg.burst_limit != '0) ? cfg.burst_limit : cfg.per_second_limit;
    assign sec_block = (cfg.per_second_limit != '0) && (sec_count >= sec_cap);
    assign min_block = (cfg.minute_cap != '0) && (min_count >= cfg.minute_cap);
    assign check_ok  = !cfg.limit_enabled || (!sec_block && !min_block);

    // A push into a full log overwrites the oldest entry, so the fill holds.
    assign sec_grow = push && !sec_full && (sec_count != '1);
    assign min_grow = push && !min_full && (min_count != '1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        run       = 1'b0;
        finish    = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_WORK:
            begin
                run    = !pass_reg;
                // decide once neither log popped this cycle
                finish = (pass_reg || (sec_done && min_done)) && out_free;
                push   = finish && !pass_reg && (query_reg == REQ_CHECK)
                         && cfg.limit_enabled && !sec_block && !min_block;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign sec_ctl = '{clear: log_clear, run: run, push: push};
    assign min_ctl = '{clear: log_clear, run: run, push: push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= req.req_type;
            pass_reg  <= !(req.rule_hit && cfg.rule_present);
            now_reg   <= TIME_BITS'(req.now_ms);
        end
    end

    assign out_valid_next = finish ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (pass_reg)
            begin
                out_allowed_reg <= (query_reg == REQ_CHECK);
                out_sec_reg     <= '0;
                out_min_reg     <= '0;
            end
            else
            begin
                out_allowed_reg <= (query_reg == REQ_CHECK) && check_ok;
                // counts as they stand after the push
                out_sec_reg     <= sec_grow ? sec_count + 1'b1 : sec_count;
                out_min_reg     <= min_grow ? min_count + 1'b1 : min_count;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.allowed      = out_allowed_reg;
    assign rsp.second_count = out_sec_reg;
    assign rsp.minute_count = out_min_reg;

endmodule
